// ===== rtl/rtpv_pkg.sv =====
// ----------------------------------------------------------------------------
// Raw transaction parser package
// Shared types and constants for the raw transaction output value parser.
// ----------------------------------------------------------------------------
package rtpv_pkg;

    localparam int SKIP_W = 40;

    localparam logic [5:0] PREVOUT_BYTES  = 6'd36;
    localparam logic [5:0] SEQUENCE_BYTES = 6'd4;
    localparam logic [3:0] VALUE_BYTES    = 4'd8;
    localparam logic [3:0] WORD_BYTES     = 4'd4;

    // Compact-size prefix codes and total field lengths.
    localparam logic [7:0] CS_PREFIX_16 = 8'hFD;
    localparam logic [7:0] CS_PREFIX_32 = 8'hFE;
    localparam logic [3:0] CS_LEN_8     = 4'd1;
    localparam logic [3:0] CS_LEN_16    = 4'd3;
    localparam logic [3:0] CS_LEN_32    = 4'd5;
    localparam logic [3:0] CS_LEN_64    = 4'd9;

    typedef enum logic [6:0] {
        PH_VERSION   = 7'b0000001,
        PH_IN_COUNT  = 7'b0000010,
        PH_IN_BODY   = 7'b0000100,
        PH_OUT_COUNT = 7'b0001000,
        PH_OUT_VALUE = 7'b0010000,
        PH_OUT_BODY  = 7'b0100000,
        PH_LOCKTIME  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [31:0] tx_version;
        logic [31:0] input_total;
        logic [31:0] output_total;
        logic [63:0] selected_amount;
        logic        selected_found;
        logic [31:0] tx_lock_time;
        logic        length_overflow;
    } result_t;

endpackage

// ===== rtl/raw_tx_output_value_parser.sv =====
// ----------------------------------------------------------------------------
// Raw transaction output value parser
// Parses a serialized legacy transaction byte stream and reports version,
// counts, the selected output's value, the lock time and a length overflow flag.
// ----------------------------------------------------------------------------
// The block takes one transaction byte per clock cycle, without gaps, for as
// long as the summary side keeps up. Each byte passes an input register and
// is then parsed; the summary built from the last lock-time byte goes into
// the result register, or into the second entry while the first waits. A
// two-entry result buffer lets the byte stream keep flowing while one summary
// waits to be taken; a second waiting summary stalls the byte input. The
// selected output index is written through the configuration channel, which
// is always ready, and should be changed only while no transaction is in
// flight.
// ----------------------------------------------------------------------------
module raw_tx_output_value_parser (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] selected_output_index,

    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] tx_version,
    output logic [31:0] input_total,
    output logic [31:0] output_total,
    output logic [63:0] selected_amount,
    output logic        selected_found,
    output logic [31:0] tx_lock_time,
    output logic        length_overflow
);

    logic [31:0]       sel_index_reg;
    logic              take;
    logic              hold;
    logic [7:0]        byte_q;
    logic              res_valid;
    rtpv_pkg::result_t res;
    rtpv_pkg::result_t out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_index_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sel_index_reg <= selected_output_index;
        end
    end

    rtpv_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .hold       (hold),
        .take       (take),
        .byte_out   (byte_q)
    );

    rtpv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (take),
        .byte_in   (byte_q),
        .sel_index (sel_index_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    rtpv_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (hold),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign tx_version      = out_data.tx_version;
    assign input_total     = out_data.input_total;
    assign output_total    = out_data.output_total;
    assign selected_amount = out_data.selected_amount;
    assign selected_found  = out_data.selected_found;
    assign tx_lock_time    = out_data.tx_lock_time;
    assign length_overflow = out_data.length_overflow;

endmodule

// ===== rtl/rtpv_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one stream byte for the parser and refills in the same cycle it is
// consumed.
// ----------------------------------------------------------------------------
module rtpv_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_ready,
    input  logic [7:0] data_byte,
    input  logic       hold,
    output logic       take,
    output logic [7:0] byte_out
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign take       = valid_reg && !hold;
    assign data_ready = !valid_reg || take;
    assign byte_out   = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (data_ready)
        begin
            valid_reg <= data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_ready && data_valid)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

// ===== rtl/rtpv_parser.sv =====
// ----------------------------------------------------------------------------
// Transaction field parser
// Walks the serialized fields one byte per cycle while fire is set and
// produces the summary when the last lock-time byte arrives.
// ----------------------------------------------------------------------------
module rtpv_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            byte_in,
    input  logic [31:0]           sel_index,
    output logic                  res_valid,
    output rtpv_pkg::result_t     res
);

    rtpv_pkg::phase_t             phase_reg, phase_next;
    logic [rtpv_pkg::SKIP_W-1:0]  skip_reg, skip_next;
    logic [7:0]                   prefix_reg, prefix_next;
    logic [3:0]                   fill_reg, fill_next;
    logic [31:0]                  seen_reg, seen_next;
    logic [63:0]                  acc_reg, acc_next;
    logic [31:0]                  version_reg, version_next;
    logic [31:0]                  in_count_reg, in_count_next;
    logic [31:0]                  out_count_reg, out_count_next;
    logic [63:0]                  amount_reg, amount_next;
    logic                         found_reg, found_next;
    logic                         overflow_reg, overflow_next;

    // Fixed-width little-endian assembly.
    logic [2:0]  fix_pos;
    logic [63:0] fix_acc;
    logic [3:0]  fix_fill;

    // Compact-size collection: the prefix is kept apart, the payload bytes
    // go into the shared accumulator.
    logic [7:0]  cs_prefix;
    logic [2:0]  cs_pos;
    logic [63:0] cs_acc;
    logic [3:0]  cs_fill;
    logic [3:0]  cs_need;
    logic        cs_done;
    logic [63:0] cs_raw;
    logic        cs_ovf;
    logic [31:0] cs_val;

    logic [rtpv_pkg::SKIP_W-1:0] skip_dec;
    logic [31:0] seen_inc;

    assign fix_pos  = fill_reg[2:0];
    assign fix_acc  = acc_reg | ({56'd0, byte_in} << {fix_pos, 3'b000});
    assign fix_fill = {1'b0, fix_pos} + 4'd1;

    assign cs_prefix = (fill_reg == 4'd0) ? byte_in : prefix_reg;
    assign cs_pos    = fill_reg[2:0] - 3'd1;
    assign cs_acc    = (fill_reg == 4'd0) ? acc_reg
                     : (acc_reg | ({56'd0, byte_in} << {cs_pos, 3'b000}));
    assign cs_fill   = fill_reg + 4'd1;

    always_comb
    begin
        if (cs_prefix < rtpv_pkg::CS_PREFIX_16)
        begin
            cs_need = rtpv_pkg::CS_LEN_8;
        end
        else if (cs_prefix == rtpv_pkg::CS_PREFIX_16)
        begin
            cs_need = rtpv_pkg::CS_LEN_16;
        end
        else if (cs_prefix == rtpv_pkg::CS_PREFIX_32)
        begin
            cs_need = rtpv_pkg::CS_LEN_32;
        end
        else
        begin
            cs_need = rtpv_pkg::CS_LEN_64;
        end
    end

    assign cs_done  = cs_fill >= cs_need;
    assign cs_raw   = (cs_need == rtpv_pkg::CS_LEN_8) ? {56'd0, cs_prefix} : cs_acc;
    assign cs_ovf   = |cs_raw[63:32];
    assign cs_val   = cs_ovf ? 32'hFFFF_FFFF : cs_raw[31:0];

    assign skip_dec = skip_reg - {{(rtpv_pkg::SKIP_W-1){1'b0}}, 1'b1};
    assign seen_inc = seen_reg + 32'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        prefix_next    = prefix_reg;
        fill_next      = fill_reg;
        seen_next      = seen_reg;
        acc_next       = acc_reg;
        version_next   = version_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        amount_next    = amount_reg;
        found_next     = found_reg;
        overflow_next  = overflow_reg;
        res_valid      = 1'b0;

        res.tx_version      = version_reg;
        res.input_total     = in_count_reg;
        res.output_total    = out_count_reg;
        res.selected_amount = amount_reg;
        res.selected_found  = found_reg;
        res.tx_lock_time    = fix_acc[31:0];
        res.length_overflow = overflow_reg;

        if (fire)
        begin
            case (phase_reg)
                rtpv_pkg::PH_VERSION:
                begin
                    acc_next  = fix_acc;
                    fill_next = fix_fill;
                    if (fix_fill >= rtpv_pkg::WORD_BYTES)
                    begin
                        version_next = fix_acc[31:0];
                        acc_next     = 64'd0;
                        fill_next    = 4'd0;
                        phase_next   = rtpv_pkg::PH_IN_COUNT;
                    end
                end

                rtpv_pkg::PH_IN_COUNT:
                begin
                    prefix_next = cs_prefix;
                    acc_next    = cs_acc;
                    fill_next   = cs_fill;
                    if (cs_done)
                    begin
                        acc_next      = 64'd0;
                        fill_next     = 4'd0;
                        overflow_next = overflow_reg | cs_ovf;
                        in_count_next = cs_val;
                        seen_next     = 32'd0;
                        if (cs_val == 32'd0)
                        begin
                            phase_next = rtpv_pkg::PH_OUT_COUNT;
                        end
                        else
                        begin
                            skip_next  = {{(rtpv_pkg::SKIP_W-6){1'b0}},
                                          rtpv_pkg::PREVOUT_BYTES};
                            phase_next = rtpv_pkg::PH_IN_BODY;
                        end
                    end
                end

                rtpv_pkg::PH_IN_BODY:
                begin
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == '0 && seen_reg >= in_count_reg)
                        begin
                            phase_next = rtpv_pkg::PH_OUT_COUNT;
                        end
                    end
                    else
                    begin
                        prefix_next = cs_prefix;
                        acc_next    = cs_acc;
                        fill_next   = cs_fill;
                        if (cs_done)
                        begin
                            acc_next      = 64'd0;
                            fill_next     = 4'd0;
                            overflow_next = overflow_reg | cs_ovf;
                            seen_next     = seen_inc;
                            // Script, sequence, and the next prevout if another
                            // input follows.
                            skip_next = {8'd0, cs_val}
                                      + {{(rtpv_pkg::SKIP_W-6){1'b0}},
                                         rtpv_pkg::SEQUENCE_BYTES}
                                      + ((seen_inc < in_count_reg)
                                         ? {{(rtpv_pkg::SKIP_W-6){1'b0}},
                                            rtpv_pkg::PREVOUT_BYTES}
                                         : {rtpv_pkg::SKIP_W{1'b0}});
                        end
                    end
                end

                rtpv_pkg::PH_OUT_COUNT:
                begin
                    prefix_next = cs_prefix;
                    acc_next    = cs_acc;
                    fill_next   = cs_fill;
                    if (cs_done)
                    begin
                        acc_next       = 64'd0;
                        fill_next      = 4'd0;
                        overflow_next  = overflow_reg | cs_ovf;
                        out_count_next = cs_val;
                        seen_next      = 32'd0;
                        phase_next     = (cs_val == 32'd0) ? rtpv_pkg::PH_LOCKTIME
                                                           : rtpv_pkg::PH_OUT_VALUE;
                    end
                end

                rtpv_pkg::PH_OUT_VALUE:
                begin
                    acc_next  = fix_acc;
                    fill_next = fix_fill;
                    if (fix_fill >= rtpv_pkg::VALUE_BYTES)
                    begin
                        if (seen_reg == sel_index)
                        begin
                            amount_next = fix_acc;
                            found_next  = 1'b1;
                        end
                        acc_next   = 64'd0;
                        fill_next  = 4'd0;
                        skip_next  = '0;
                        phase_next = rtpv_pkg::PH_OUT_BODY;
                    end
                end

                rtpv_pkg::PH_OUT_BODY:
                begin
                    if (skip_reg != '0)
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == '0)
                        begin
                            seen_next  = seen_inc;
                            acc_next   = 64'd0;
                            fill_next  = 4'd0;
                            phase_next = (seen_inc < out_count_reg)
                                       ? rtpv_pkg::PH_OUT_VALUE : rtpv_pkg::PH_LOCKTIME;
                        end
                    end
                    else
                    begin
                        prefix_next = cs_prefix;
                        acc_next    = cs_acc;
                        fill_next   = cs_fill;
                        if (cs_done)
                        begin
                            acc_next      = 64'd0;
                            fill_next     = 4'd0;
                            overflow_next = overflow_reg | cs_ovf;
                            skip_next     = {8'd0, cs_val};
                            // An empty script ends the output right here.
                            if (cs_val == 32'd0)
                            begin
                                seen_next  = seen_inc;
                                phase_next = (seen_inc < out_count_reg)
                                           ? rtpv_pkg::PH_OUT_VALUE
                                           : rtpv_pkg::PH_LOCKTIME;
                            end
                        end
                    end
                end

                rtpv_pkg::PH_LOCKTIME:
                begin
                    acc_next  = fix_acc;
                    fill_next = fix_fill;
                    if (fix_fill >= rtpv_pkg::WORD_BYTES)
                    begin
                        res_valid      = 1'b1;
                        phase_next     = rtpv_pkg::PH_VERSION;
                        skip_next      = '0;
                        fill_next      = 4'd0;
                        seen_next      = 32'd0;
                        acc_next       = 64'd0;
                        version_next   = 32'd0;
                        in_count_next  = 32'd0;
                        out_count_next = 32'd0;
                        amount_next    = 64'd0;
                        found_next     = 1'b0;
                        overflow_next  = 1'b0;
                    end
                end

                default:
                begin
                    // A corrupt phase restarts the parse with this byte as the
                    // first version byte.
                    phase_next     = rtpv_pkg::PH_VERSION;
                    skip_next      = '0;
                    fill_next      = 4'd1;
                    seen_next      = 32'd0;
                    acc_next       = {56'd0, byte_in};
                    version_next   = 32'd0;
                    in_count_next  = 32'd0;
                    out_count_next = 32'd0;
                    amount_next    = 64'd0;
                    found_next     = 1'b0;
                    overflow_next  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rtpv_pkg::PH_VERSION;
            skip_reg      <= '0;
            prefix_reg    <= 8'd0;
            fill_reg      <= 4'd0;
            seen_reg      <= 32'd0;
            acc_reg       <= 64'd0;
            version_reg   <= 32'd0;
            in_count_reg  <= 32'd0;
            out_count_reg <= 32'd0;
            amount_reg    <= 64'd0;
            found_reg     <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            prefix_reg    <= prefix_next;
            fill_reg      <= fill_next;
            seen_reg      <= seen_next;
            acc_reg       <= acc_next;
            version_reg   <= version_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            amount_reg    <= amount_next;
            found_reg     <= found_next;
            overflow_reg  <= overflow_next;
        end
    end

endmodule

// ===== rtl/rtpv_out_buf.sv =====
// ----------------------------------------------------------------------------
// Result register with skid stage
// Holds the summary for the consumer; a second entry catches a summary that
// completes while the first is still waiting.
// ----------------------------------------------------------------------------
module rtpv_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    input  rtpv_pkg::result_t     res,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rtpv_pkg::result_t     out_data
);

    logic              head_valid_reg;
    rtpv_pkg::result_t head_reg;
    logic              skid_valid_reg;
    rtpv_pkg::result_t skid_reg;
    logic              head_free;

    assign head_free = !head_valid_reg || out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (head_free)
        begin
            head_valid_reg <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_free)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
            end
            else if (res_valid)
            begin
                head_reg <= res;
            end
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

endmodule
